### src/scsc_pkg.sv
package scsc_pkg;

  // Grid and field sizes
  localparam int unsigned MAX_POINTS = 1024;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned CELL_W     = 10;
  localparam int unsigned NODE_W     = 31;
  localparam int unsigned POS_W      = 33;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned NUM_VERT   = 8;
  localparam int unsigned VSEL_W     = 3;
  localparam int unsigned TCNT_W     = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_POINTS_I = 2'd0,
    CFG_POINTS_J = 2'd1,
    CFG_POINTS_K = 2'd2
  } cfg_idx_e;

  // Element kinds on the result port
  typedef enum logic [KIND_W-1:0] {
    EK_BAR = 2'd0,
    EK_TRI = 2'd1,
    EK_TET = 2'd2
  } elem_kind_e;

  // How a cell is split, including which axis or plane the grid uses
  typedef enum logic [3:0] {
    SH_BAD,
    SH_BAR_I,
    SH_BAR_K,
    SH_BAR_J,
    SH_TRI_IJ,
    SH_TRI_IK,
    SH_TRI_JK,
    SH_TET_EVEN,
    SH_TET_ODD
  } shape_e;

  // Clamped point counts
  typedef struct packed {
    logic [CNT_W-1:0] ni;
    logic [CNT_W-1:0] nj;
    logic [CNT_W-1:0] nk;
  } grid_t;

  // One cell, ready to be split into elements
  typedef struct packed {
    shape_e                         shape;
    logic [POS_W-1:0]               pos_base;
    logic [NUM_VERT-1:0][NODE_W-1:0] verts;
  } cell_rec_t;

  // One result item
  typedef struct packed {
    logic                    valid;
    logic [POS_W-1:0]        pos;
    elem_kind_e              kind;
    logic [3:0][NODE_W-1:0]  nodes;
    logic                    last;
    logic                    bad;
  } res_t;

  // Corner selection for the four node slots, slot 0 first
  typedef logic [3:0][VSEL_W-1:0] vsel_t;

  function automatic vsel_t mk_row(logic [VSEL_W-1:0] a, logic [VSEL_W-1:0] b,
                                   logic [VSEL_W-1:0] c, logic [VSEL_W-1:0] d);
    vsel_t r;
    r[0] = a;
    r[1] = b;
    r[2] = c;
    r[3] = d;
    return r;
  endfunction

  // Number of elements a cell gives; also the position stride
  function automatic logic [TCNT_W-1:0] shape_count(shape_e s);
    logic [TCNT_W-1:0] n;
    case (s)
      SH_TRI_IJ, SH_TRI_IK, SH_TRI_JK: n = TCNT_W'(2);
      SH_TET_EVEN, SH_TET_ODD:         n = TCNT_W'(5);
      default:                         n = TCNT_W'(1);
    endcase
    return n;
  endfunction

  function automatic elem_kind_e shape_kind(shape_e s);
    elem_kind_e k;
    case (s)
      SH_TRI_IJ, SH_TRI_IK, SH_TRI_JK: k = EK_TRI;
      SH_TET_EVEN, SH_TET_ODD:         k = EK_TET;
      default:                         k = EK_BAR;
    endcase
    return k;
  endfunction

  // Node slots that carry a vertex
  function automatic logic [3:0] shape_used(shape_e s);
    logic [3:0] m;
    case (s)
      SH_BAR_I, SH_BAR_K, SH_BAR_J:    m = 4'b0011;
      SH_TRI_IJ, SH_TRI_IK, SH_TRI_JK: m = 4'b0111;
      SH_TET_EVEN, SH_TET_ODD:         m = 4'b1111;
      default:                         m = 4'b0000;
    endcase
    return m;
  endfunction

  // Cell corners for element t of a cell
  function automatic vsel_t shape_row(shape_e s, logic [TCNT_W-1:0] t);
    vsel_t r;
    r = mk_row(3'd0, 3'd0, 3'd0, 3'd0);
    case (s)
      SH_BAR_I:  r = mk_row(3'd0, 3'd1, 3'd0, 3'd0);
      SH_BAR_K:  r = mk_row(3'd0, 3'd4, 3'd0, 3'd0);
      SH_BAR_J:  r = mk_row(3'd0, 3'd3, 3'd0, 3'd0);
      SH_TRI_IJ: r = (t == '0) ? mk_row(3'd0, 3'd1, 3'd2, 3'd0)
                               : mk_row(3'd0, 3'd2, 3'd3, 3'd0);
      SH_TRI_IK: r = (t == '0) ? mk_row(3'd0, 3'd4, 3'd5, 3'd0)
                               : mk_row(3'd0, 3'd5, 3'd1, 3'd0);
      SH_TRI_JK: r = (t == '0) ? mk_row(3'd0, 3'd3, 3'd7, 3'd0)
                               : mk_row(3'd0, 3'd7, 3'd4, 3'd0);
      SH_TET_EVEN: begin
        case (t)
          3'd0:    r = mk_row(3'd0, 3'd1, 3'd3, 3'd4);
          3'd1:    r = mk_row(3'd1, 3'd2, 3'd3, 3'd6);
          3'd2:    r = mk_row(3'd3, 3'd4, 3'd6, 3'd7);
          3'd3:    r = mk_row(3'd1, 3'd4, 3'd5, 3'd6);
          default: r = mk_row(3'd1, 3'd3, 3'd4, 3'd6);
        endcase
      end
      SH_TET_ODD: begin
        case (t)
          3'd0:    r = mk_row(3'd0, 3'd2, 3'd3, 3'd7);
          3'd1:    r = mk_row(3'd0, 3'd1, 3'd2, 3'd5);
          3'd2:    r = mk_row(3'd2, 3'd5, 3'd6, 3'd7);
          3'd3:    r = mk_row(3'd5, 3'd4, 3'd7, 3'd0);
          default: r = mk_row(3'd5, 3'd2, 3'd0, 3'd7);
        endcase
      end
      default: r = mk_row(3'd0, 3'd0, 3'd0, 3'd0);
    endcase
    return r;
  endfunction

endpackage

### src/scsc_geom.sv
module scsc_geom (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [scsc_pkg::CELL_W-1:0] cell_i_i,
  input  logic [scsc_pkg::CELL_W-1:0] cell_j_i,
  input  logic [scsc_pkg::CELL_W-1:0] cell_k_i,
  input  scsc_pkg::grid_t            grid_i,
  output logic                       rec_valid_o,
  output scsc_pkg::cell_rec_t        rec_o,
  input  logic                       rec_take_i
);
  import scsc_pkg::*;

  localparam int unsigned NN_W  = 2 * CNT_W;
  localparam int unsigned N11_W = 2 * CELL_W;
  localparam int unsigned CN_W  = CELL_W + CNT_W;
  localparam int unsigned SP_W  = CN_W + 1;
  localparam int unsigned LP_W  = N11_W + 1;
  localparam int unsigned CNN_W = CELL_W + NN_W;
  localparam int unsigned CN11_W = CELL_W + N11_W;

  typedef struct packed {
    logic [CELL_W-1:0] ci;
    logic [CELL_W-1:0] cj;
    logic [CELL_W-1:0] ck;
    logic [CNT_W-1:0]  ni;
    logic [CNT_W-1:0]  nj;
    logic [CELL_W-1:0] ni1;
    logic [CELL_W-1:0] nj1;
    shape_e            shape;
  } s1_t;

  typedef struct packed {
    logic [CELL_W-1:0] ci;
    logic [CELL_W-1:0] ck;
    logic [CNT_W-1:0]  ni;
    logic [NN_W-1:0]   ninj;
    logic [N11_W-1:0]  n11;
    logic [CN_W-1:0]   cjni;
    logic [N11_W-1:0]  cjn1;
    shape_e            shape;
  } s2_t;

  typedef struct packed {
    logic [CNT_W-1:0]  ni;
    logic [NN_W-1:0]   ninj;
    logic [SP_W-1:0]   spart;
    logic [LP_W-1:0]   lpart;
    logic [CNN_W-1:0]  ckninj;
    logic [CN11_W-1:0] ckn11;
    shape_e            shape;
  } s3_t;

  typedef struct packed {
    logic [CNT_W-1:0]  ni;
    logic [NN_W-1:0]   ninj;
    logic [NODE_W-1:0] v0;
    logic [NODE_W-1:0] lin;
    shape_e            shape;
  } s4_t;

  s1_t       s1_d, s1_q;
  s2_t       s2_d, s2_q;
  s3_t       s3_d, s3_q;
  s4_t       s4_d, s4_q;
  cell_rec_t s5_d, s5_q;
  logic      v1_q, v2_q, v3_q, v4_q, v5_q;
  logic      rdy1, rdy2, rdy3, rdy4, rdy5;

  // Advance a stage when it is empty or the one after it moves on
  assign rdy5       = !v5_q || rec_take_i;
  assign rdy4       = !v4_q || rdy5;
  assign rdy3       = !v3_q || rdy4;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: grid dimension, axis choice, bounds check
  always_comb begin
    logic one_i, one_j, one_k;
    logic [1:0] n_one;
    logic bad;
    logic [CELL_W-1:0] nk1;
    s1_d.ci = cell_i_i;
    s1_d.cj = cell_j_i;
    s1_d.ck = cell_k_i;
    s1_d.ni = grid_i.ni;
    s1_d.nj = grid_i.nj;
    one_i = (grid_i.ni == CNT_W'(1));
    one_j = (grid_i.nj == CNT_W'(1));
    one_k = (grid_i.nk == CNT_W'(1));
    s1_d.ni1 = one_i ? CELL_W'(1) : CELL_W'(grid_i.ni - CNT_W'(1));
    s1_d.nj1 = one_j ? CELL_W'(1) : CELL_W'(grid_i.nj - CNT_W'(1));
    nk1      = one_k ? CELL_W'(1) : CELL_W'(grid_i.nk - CNT_W'(1));
    n_one = 2'(one_i) + 2'(one_j) + 2'(one_k);
    bad = (one_i && one_j && one_k) || (cell_i_i >= s1_d.ni1) ||
          (cell_j_i >= s1_d.nj1) || (cell_k_i >= nk1);
    if (bad) begin
      s1_d.shape = SH_BAD;
    end else if (n_one == 2'd2) begin
      if (nk1 == CELL_W'(1) && s1_d.nj1 == CELL_W'(1)) begin
        s1_d.shape = SH_BAR_I;
      end else if (s1_d.ni1 == CELL_W'(1) && s1_d.nj1 == CELL_W'(1)) begin
        s1_d.shape = SH_BAR_K;
      end else begin
        s1_d.shape = SH_BAR_J;
      end
    end else if (n_one == 2'd1) begin
      if (nk1 == CELL_W'(1)) begin
        s1_d.shape = SH_TRI_IJ;
      end else if (s1_d.nj1 == CELL_W'(1)) begin
        s1_d.shape = SH_TRI_IK;
      end else begin
        s1_d.shape = SH_TRI_JK;
      end
    end else begin
      s1_d.shape = (cell_i_i[0] ^ cell_j_i[0] ^ cell_k_i[0]) ? SH_TET_ODD : SH_TET_EVEN;
    end
  end

  // Stage 2: plane sizes and the j products
  always_comb begin
    s2_d.ci    = s1_q.ci;
    s2_d.ck    = s1_q.ck;
    s2_d.ni    = s1_q.ni;
    s2_d.ninj  = NN_W'(s1_q.ni) * NN_W'(s1_q.nj);
    s2_d.n11   = N11_W'(s1_q.ni1) * N11_W'(s1_q.nj1);
    s2_d.cjni  = CN_W'(s1_q.cj) * CN_W'(s1_q.ni);
    s2_d.cjn1  = N11_W'(s1_q.cj) * N11_W'(s1_q.ni1);
    s2_d.shape = s1_q.shape;
  end

  // Stage 3: the k products and partial sums
  always_comb begin
    s3_d.ni     = s2_q.ni;
    s3_d.ninj   = s2_q.ninj;
    s3_d.spart  = SP_W'(s2_q.cjni) + SP_W'(s2_q.ci) + SP_W'(1);
    s3_d.lpart  = LP_W'(s2_q.cjn1) + LP_W'(s2_q.ci);
    s3_d.ckninj = CNN_W'(s2_q.ck) * CNN_W'(s2_q.ninj);
    s3_d.ckn11  = CN11_W'(s2_q.ck) * CN11_W'(s2_q.n11);
    s3_d.shape  = s2_q.shape;
  end

  // Stage 4: base corner index and linear cell number
  always_comb begin
    logic [CNN_W-1:0] v0_full;
    v0_full    = s3_q.ckninj + CNN_W'(s3_q.spart);
    s4_d.ni    = s3_q.ni;
    s4_d.ninj  = s3_q.ninj;
    s4_d.v0    = v0_full[NODE_W-1:0];
    s4_d.lin   = NODE_W'(s3_q.ckn11) + NODE_W'(s3_q.lpart);
    s4_d.shape = s3_q.shape;
  end

  // Stage 5: all eight corners and the first element position
  always_comb begin
    logic [NODE_W-1:0] dni, dnn, one;
    logic [POS_W-1:0]  lin;
    dni = NODE_W'(s4_q.ni);
    dnn = NODE_W'(s4_q.ninj);
    one = NODE_W'(1);
    lin = POS_W'(s4_q.lin);
    s5_d.shape    = s4_q.shape;
    s5_d.verts[0] = s4_q.v0;
    s5_d.verts[1] = s4_q.v0 + one;
    s5_d.verts[2] = s4_q.v0 + dni + one;
    s5_d.verts[3] = s4_q.v0 + dni;
    s5_d.verts[4] = s4_q.v0 + dnn;
    s5_d.verts[5] = s4_q.v0 + dnn + one;
    s5_d.verts[6] = s4_q.v0 + dni + dnn + one;
    s5_d.verts[7] = s4_q.v0 + dni + dnn;
    case (s4_q.shape)
      SH_BAR_I, SH_BAR_K, SH_BAR_J:    s5_d.pos_base = lin;
      SH_TRI_IJ, SH_TRI_IK, SH_TRI_JK: s5_d.pos_base = lin << 1;
      SH_TET_EVEN, SH_TET_ODD:         s5_d.pos_base = (lin << 2) + lin;
      default:                         s5_d.pos_base = '0;
    endcase
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // Stage payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (rdy1) s1_q <= s1_d;
    if (rdy2) s2_q <= s2_d;
    if (rdy3) s3_q <= s3_d;
    if (rdy4) s4_q <= s4_d;
    if (rdy5) s5_q <= s5_d;
  end

  assign rec_valid_o = v5_q;
  assign rec_o       = s5_q;

endmodule

### src/scsc_emit.sv
module scsc_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rec_valid_i,
  input  scsc_pkg::cell_rec_t rec_i,
  output logic                rec_take_o,
  output scsc_pkg::res_t      res_o
);
  import scsc_pkg::*;

  cell_rec_t         rec_q;
  logic              act_q, act_d;
  logic [TCNT_W-1:0] cnt_q, cnt_d;
  logic              last_now;
  res_t              res_d, res_q;

  // Finish the held cell on its final element, then take the next one
  assign last_now   = act_q && (cnt_q == TCNT_W'(shape_count(rec_q.shape) - TCNT_W'(1)));
  assign rec_take_o = !act_q || last_now;

  always_comb begin
    act_d = act_q;
    cnt_d = cnt_q;
    if (rec_take_o) begin
      act_d = rec_valid_i;
      cnt_d = '0;
    end else begin
      cnt_d = cnt_q + TCNT_W'(1);
    end
  end

  // Build the current element from the held cell
  always_comb begin
    vsel_t      row;
    logic [3:0] used;
    row  = shape_row(rec_q.shape, cnt_q);
    used = shape_used(rec_q.shape);
    res_d.valid = act_q;
    res_d.pos   = rec_q.pos_base + POS_W'(cnt_q);
    res_d.kind  = (rec_q.shape == SH_BAD) ? EK_BAR : shape_kind(rec_q.shape);
    for (int n = 0; n < 4; n++) begin
      res_d.nodes[n] = used[n] ? rec_q.verts[row[n]] : '0;
    end
    res_d.last = last_now;
    res_d.bad  = (rec_q.shape == SH_BAD);
  end

  // Sequencer state and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
      res_q <= '0;
    end else begin
      act_q <= act_d;
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  // Hold the cell record
  always_ff @(posedge clk_i) begin
    if (rec_take_o && rec_valid_i) rec_q <= rec_i;
  end

  assign res_o = res_q;

endmodule

### src/structured_cell_to_simplex_connectivity_core.sv
// Structured grid cell to simplex connectivity.
//
// Input: one cell (cell_i_i, cell_j_i, cell_k_i) is taken at a clock edge
// with start high and busy low. Output: each element appears for one cycle
// with result_valid_o high; last_of_cell_o marks the cell's final element and
// bad_cell_o a cell outside the grid. The receiver always takes a result.
// Configuration: cfg_we_i writes cfg_data_i to point count cfg_idx_i
// (0 i, 1 j, 2 k) at once; write only while the block is idle.
// Path: the first element of a cell reaches the result ports through five
// arithmetic stages, the element sequencer and the output register; the
// accepting edge loads the first of them. Rate: the sequencer issues one
// element per cycle and takes a new cell when empty or on the held cell's
// final element (one for a bar or a bad cell, two for a 2D cell, five for a
// 3D cell); the stages ahead fill up and busy rises meanwhile.
// Reset: counts return to 2 each, the pipeline empties, no result is shown.
module structured_cell_to_simplex_connectivity_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [scsc_pkg::CELL_W-1:0] cell_i_i,
  input  logic [scsc_pkg::CELL_W-1:0] cell_j_i,
  input  logic [scsc_pkg::CELL_W-1:0] cell_k_i,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [scsc_pkg::CNT_W-1:0]  cfg_data_i,
  output logic                        result_valid_o,
  output logic [scsc_pkg::POS_W-1:0]  element_position_o,
  output logic [scsc_pkg::KIND_W-1:0] element_kind_o,
  output logic [scsc_pkg::NODE_W-1:0] node_first_o,
  output logic [scsc_pkg::NODE_W-1:0] node_second_o,
  output logic [scsc_pkg::NODE_W-1:0] node_third_o,
  output logic [scsc_pkg::NODE_W-1:0] node_fourth_o,
  output logic                        last_of_cell_o,
  output logic                        bad_cell_o
);
  import scsc_pkg::*;

  logic [CNT_W-1:0] pts_i_q, pts_j_q, pts_k_q;
  grid_t            grid;
  logic             in_ready;
  logic             rec_valid;
  cell_rec_t        rec;
  logic             rec_take;
  res_t             res;

  // Point count registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pts_i_q <= CNT_W'(2);
      pts_j_q <= CNT_W'(2);
      pts_k_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_POINTS_I: pts_i_q <= cfg_data_i;
        CFG_POINTS_J: pts_j_q <= cfg_data_i;
        CFG_POINTS_K: pts_k_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp counts to the supported range
  always_comb begin
    grid.ni = (pts_i_q == '0) ? CNT_W'(1) :
              (pts_i_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pts_i_q;
    grid.nj = (pts_j_q == '0) ? CNT_W'(1) :
              (pts_j_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pts_j_q;
    grid.nk = (pts_k_q == '0) ? CNT_W'(1) :
              (pts_k_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pts_k_q;
  end

  assign busy = !in_ready;

  scsc_geom u_geom (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start),
    .in_ready_o  (in_ready),
    .cell_i_i    (cell_i_i),
    .cell_j_i    (cell_j_i),
    .cell_k_i    (cell_k_i),
    .grid_i      (grid),
    .rec_valid_o (rec_valid),
    .rec_o       (rec),
    .rec_take_i  (rec_take)
  );

  scsc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (rec_valid),
    .rec_i       (rec),
    .rec_take_o  (rec_take),
    .res_o       (res)
  );

  // Drive the result ports
  assign result_valid_o     = res.valid;
  assign element_position_o = res.pos;
  assign element_kind_o     = res.kind;
  assign node_first_o       = res.nodes[0];
  assign node_second_o      = res.nodes[1];
  assign node_third_o       = res.nodes[2];
  assign node_fourth_o      = res.nodes[3];
  assign last_of_cell_o     = res.last;
  assign bad_cell_o         = res.bad;

endmodule

### tb/sv/tb_structured_cell_to_simplex_connectivity_core.sv
module tb_structured_cell_to_simplex_connectivity_core;
  import scsc_pkg::*;

  // Corner numbers of the five tetrahedra, 12 bits per tetrahedron, slot 0 lowest
  localparam logic [59:0] SPLIT_EVEN = {3'd6, 3'd4, 3'd3, 3'd1,  3'd6, 3'd5, 3'd4, 3'd1,
                                        3'd7, 3'd6, 3'd4, 3'd3,  3'd6, 3'd3, 3'd2, 3'd1,
                                        3'd4, 3'd3, 3'd1, 3'd0};
  localparam logic [59:0] SPLIT_ODD  = {3'd7, 3'd0, 3'd2, 3'd5,  3'd0, 3'd7, 3'd4, 3'd5,
                                        3'd7, 3'd6, 3'd5, 3'd2,  3'd5, 3'd2, 3'd1, 3'd0,
                                        3'd7, 3'd3, 3'd2, 3'd0};
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [CELL_W-1:0] ci;
    logic [CELL_W-1:0] cj;
    logic [CELL_W-1:0] ck;
  } cell_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    elem_kind_e        kind;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_c;
    logic [NODE_W-1:0] node_d;
    logic              last;
    logic              bad;
  } element_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cell_start = 1'b0;
  logic              cell_busy;
  logic [CELL_W-1:0] cell_i = '0;
  logic [CELL_W-1:0] cell_j = '0;
  logic [CELL_W-1:0] cell_k = '0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_idx = '0;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              elem_valid;
  logic [POS_W-1:0]  elem_position;
  logic [KIND_W-1:0] elem_kind;
  logic [NODE_W-1:0] elem_node_a;
  logic [NODE_W-1:0] elem_node_b;
  logic [NODE_W-1:0] elem_node_c;
  logic [NODE_W-1:0] elem_node_d;
  logic              elem_last;
  logic              elem_bad;

  // Shadow of the point count registers
  logic [CNT_W-1:0]  grid_pts_i = CNT_W'(2);
  logic [CNT_W-1:0]  grid_pts_j = CNT_W'(2);
  logic [CNT_W-1:0]  grid_pts_k = CNT_W'(2);

  cell_t             pending_cells[$];
  element_t          expected_elements[$];
  int unsigned       sender_idle_pct = 0;
  int unsigned       mismatches = 0;

  structured_cell_to_simplex_connectivity_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (cell_start),
    .busy               (cell_busy),
    .cell_i_i           (cell_i),
    .cell_j_i           (cell_j),
    .cell_k_i           (cell_k),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data),
    .result_valid_o     (elem_valid),
    .element_position_o (elem_position),
    .element_kind_o     (elem_kind),
    .node_first_o       (elem_node_a),
    .node_second_o      (elem_node_b),
    .node_third_o       (elem_node_c),
    .node_fourth_o      (elem_node_d),
    .last_of_cell_o     (elem_last),
    .bad_cell_o         (elem_bad)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Saturate a raw count into 1..MAX_POINTS
  function automatic longint unsigned clamp_points(logic [CNT_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > CNT_W'(MAX_POINTS)) return MAX_POINTS;
    return 64'(raw);
  endfunction

  // Number of cells along an axis; an unused axis still has one
  function automatic longint unsigned cells_on_axis(logic [CNT_W-1:0] raw);
    longint unsigned n;
    n = clamp_points(raw);
    return (n > 1) ? n - 1 : 1;
  endfunction

  // Work out the elements one cell gives and queue them
  function automatic void predict_cell(cell_t c);
    longint unsigned ni, nj, nk, ni1, nj1, nk1, ninj;
    longint unsigned li, lj, lk, base, a, b, p1, p2, p3, p4;
    longint unsigned vtx[8];
    logic [59:0]     split;
    element_t        e;
    int              dim;
    int              t;
    ni   = clamp_points(grid_pts_i);
    nj   = clamp_points(grid_pts_j);
    nk   = clamp_points(grid_pts_k);
    ni1  = cells_on_axis(grid_pts_i);
    nj1  = cells_on_axis(grid_pts_j);
    nk1  = cells_on_axis(grid_pts_k);
    ninj = ni * nj;
    li   = 64'(c.ci);
    lj   = 64'(c.cj);
    lk   = 64'(c.ck);
    dim  = 3;
    if (ni == 1) dim = (nj == 1 || nk == 1) ? 1 : 2;
    else if (nj == 1) dim = (nk == 1) ? 1 : 2;
    else if (nk == 1) dim = 2;
    e = '0;

    // Outside the grid, or a grid of a single point
    if ((ni == 1 && nj == 1 && nk == 1) || li >= ni1 || lj >= nj1 || lk >= nk1) begin
      e.last = 1'b1;
      e.bad  = 1'b1;
      expected_elements.push_back(e);
      return;
    end

    if (dim == 1) begin
      if (nk1 == 1 && nj1 == 1) begin
        base = li;
        a    = li + 1;
        b    = a + 1;
      end else if (ni1 == 1 && nj1 == 1) begin
        base = lk;
        a    = lk * ninj + 1;
        b    = a + ninj;
      end else begin
        base = lj;
        a    = lj * ni + 1;
        b    = a + ni;
      end
      e.position = POS_W'(base);
      e.kind     = EK_BAR;
      e.node_a   = NODE_W'(a);
      e.node_b   = NODE_W'(b);
      e.last     = 1'b1;
      expected_elements.push_back(e);
      return;
    end

    if (dim == 2) begin
      if (nk1 == 1) begin
        p1   = li + lj * ni + 1;
        p2   = p1 + 1;
        p3   = p2 + ni;
        p4   = p3 - 1;
        base = 2 * (li + lj * ni1);
      end else if (nj1 == 1) begin
        p1   = li + lk * ninj + 1;
        p2   = p1 + ninj;
        p3   = p2 + 1;
        p4   = p1 + 1;
        base = 2 * (li + lk * ni1);
      end else begin
        p1   = 1 + lj * ni + lk * ninj;
        p2   = p1 + ni;
        p3   = p2 + ninj;
        p4   = p3 - ni;
        base = 2 * (lj + lk * nj1);
      end
      e.kind     = EK_TRI;
      e.position = POS_W'(base);
      e.node_a   = NODE_W'(p1);
      e.node_b   = NODE_W'(p2);
      e.node_c   = NODE_W'(p3);
      expected_elements.push_back(e);
      e.position = POS_W'(base + 1);
      e.node_b   = NODE_W'(p3);
      e.node_c   = NODE_W'(p4);
      e.last     = 1'b1;
      expected_elements.push_back(e);
      return;
    end

    // Five tetrahedra, split alternating with the parity of i+j+k
    base   = 5 * (li + lj * ni1 + lk * ni1 * nj1);
    split  = (c.ci[0] ^ c.cj[0] ^ c.ck[0]) ? SPLIT_ODD : SPLIT_EVEN;
    vtx[0] = 1 + li + lj * ni + lk * ninj;
    vtx[1] = vtx[0] + 1;
    vtx[2] = vtx[1] + ni;
    vtx[3] = vtx[2] - 1;
    vtx[4] = vtx[0] + ninj;
    vtx[5] = vtx[1] + ninj;
    vtx[6] = vtx[2] + ninj;
    vtx[7] = vtx[3] + ninj;
    e.kind = EK_TET;
    for (t = 0; t < 5; t++) begin
      e.position = POS_W'(base + t);
      e.node_a   = NODE_W'(vtx[split[t*12 +: 3]]);
      e.node_b   = NODE_W'(vtx[split[t*12 + 3 +: 3]]);
      e.node_c   = NODE_W'(vtx[split[t*12 + 6 +: 3]]);
      e.node_d   = NODE_W'(vtx[split[t*12 + 9 +: 3]]);
      e.last     = (t == 4);
      expected_elements.push_back(e);
    end
  endfunction

  function automatic bit field_ok(string fname, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // Index along one axis, leaning towards the first and the last cell
  function automatic logic [CELL_W-1:0] pick_index(longint unsigned cells);
    int unsigned r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return CELL_W'(cells - 1);
    return CELL_W'($urandom_range(0, 32'(cells - 1)));
  endfunction

  // Driver: take the item on acceptance, then offer the next one or idle
  always @(posedge clk_i) begin
    logic  go;
    cell_t nxt;
    go = cell_start;
    if (!rst_ni) begin
      go = 1'b0;
    end else begin
      if (cell_start && !cell_busy) begin
        predict_cell('{ci: cell_i, cj: cell_j, ck: cell_k});
        go = 1'b0;
      end
      if (!go && pending_cells.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
        nxt = pending_cells.pop_front();
        cell_i <= nxt.ci;
        cell_j <= nxt.cj;
        cell_k <= nxt.ck;
        go = 1'b1;
      end
    end
    cell_start <= go;
  end

  // Monitor: compare each element with the oldest expectation
  always @(posedge clk_i) begin
    element_t    want;
    int unsigned wrong;
    wrong = 0;
    if (rst_ni && elem_valid) begin
      if (expected_elements.size() == 0) begin
        $error("element with no expectation: position %0d", elem_position);
        mismatches++;
      end else begin
        want = expected_elements.pop_front();
        if (!field_ok("element_position", 64'(want.position), 64'(elem_position))) wrong++;
        if (!field_ok("element_kind", 64'(want.kind), 64'(elem_kind))) wrong++;
        if (!field_ok("node_first", 64'(want.node_a), 64'(elem_node_a))) wrong++;
        if (!field_ok("node_second", 64'(want.node_b), 64'(elem_node_b))) wrong++;
        if (!field_ok("node_third", 64'(want.node_c), 64'(elem_node_c))) wrong++;
        if (!field_ok("node_fourth", 64'(want.node_d), 64'(elem_node_d))) wrong++;
        if (!field_ok("last_of_cell", 64'(want.last), 64'(elem_last))) wrong++;
        if (!field_ok("bad_cell", 64'(want.bad), 64'(elem_bad))) wrong++;
        mismatches += wrong;
      end
    end
  end

  task automatic write_count(cfg_idx_e idx, logic [CNT_W-1:0] value);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    case (idx)
      CFG_POINTS_I: grid_pts_i = value;
      CFG_POINTS_J: grid_pts_j = value;
      default:      grid_pts_k = value;
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_grid(logic [CNT_W-1:0] ni, logic [CNT_W-1:0] nj, logic [CNT_W-1:0] nk);
    write_count(CFG_POINTS_I, ni);
    write_count(CFG_POINTS_J, nj);
    write_count(CFG_POINTS_K, nk);
  endtask

  task automatic add_cell(int unsigned ci, int unsigned cj, int unsigned ck);
    pending_cells.push_back('{ci: CELL_W'(ci), cj: CELL_W'(cj), ck: CELL_W'(ck)});
  endtask

  // Hold until every item is taken and every element has come out
  task automatic drain_all();
    while (pending_cells.size() > 0 || cell_start || expected_elements.size() > 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly cells inside the grid, a quarter of arbitrary indexes
  task automatic run_random(logic [CNT_W-1:0] ni, logic [CNT_W-1:0] nj,
                            logic [CNT_W-1:0] nk, int unsigned count, int unsigned idle);
    cell_t c;
    set_grid(ni, nj, nk);
    sender_idle_pct = idle;
    repeat (count) begin
      if ($urandom_range(0, 3) == 0) begin
        c.ci = CELL_W'($urandom_range(0, 1023));
        c.cj = CELL_W'($urandom_range(0, 1023));
        c.ck = CELL_W'($urandom_range(0, 1023));
      end else begin
        c.ci = pick_index(cells_on_axis(grid_pts_i));
        c.cj = pick_index(cells_on_axis(grid_pts_j));
        c.ck = pick_index(cells_on_axis(grid_pts_k));
      end
      pending_cells.push_back(c);
    end
    drain_all();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Counts at their reset value: a single 3D cell
    add_cell(0, 0, 0);
    add_cell(1, 0, 0);
    add_cell(0, 1, 0);
    add_cell(0, 0, 1);
    add_cell(1023, 1023, 1023);
    drain_all();

    // Small 3D grid: both splits, last cell, one past the end
    set_grid(4, 3, 3);
    add_cell(0, 0, 0);
    add_cell(1, 0, 0);
    add_cell(2, 1, 1);
    add_cell(3, 0, 0);
    drain_all();

    // Bars along each axis
    set_grid(6, 1, 1);
    add_cell(0, 0, 0);
    add_cell(4, 0, 0);
    add_cell(5, 0, 0);
    add_cell(0, 1, 0);
    drain_all();
    set_grid(1, 5, 1);
    add_cell(0, 3, 0);
    add_cell(1, 0, 0);
    drain_all();
    set_grid(1, 1, 5);
    add_cell(0, 0, 3);
    drain_all();

    // Triangles in each plane
    set_grid(4, 3, 1);
    add_cell(2, 1, 0);
    drain_all();
    set_grid(4, 1, 3);
    add_cell(2, 0, 1);
    drain_all();
    set_grid(1, 4, 3);
    add_cell(0, 2, 1);
    drain_all();

    // Zero count taken as one, oversize count saturated
    set_grid(0, 1, 2047);
    add_cell(0, 0, 1022);
    add_cell(0, 0, 1023);
    drain_all();

    // Single point grid
    set_grid(1, 1, 1);
    add_cell(0, 0, 0);
    drain_all();

    // Largest grid
    set_grid(1024, 1024, 1024);
    add_cell(1022, 1022, 1022);
    add_cell(1023, 0, 0);
    drain_all();

    // Random cells over a range of grids and sender gaps
    run_random(5, 4, 3, 45, 0);
    run_random(1024, 1024, 1024, 45, 60);
    run_random(7, 1, 1, 40, 0);
    run_random(1, 1, 1024, 40, 21);
    run_random(1, 9, 1, 40, 60);
    run_random(6, 5, 1, 45, 0);
    run_random(3, 1, 1024, 40, 21);
    run_random(1, 2047, 3, 40, 60);
    run_random(2, 2, 2, 30, 21);
    run_random(0, 0, 0, 15, 0);
    run_random(17, 13, 11, 45, 60);
    run_random(2047, 2, 0, 40, 21);
    run_random(1024, 3, 1024, 45, 0);

    if (mismatches == 0) begin
      $display("tb_structured_cell_to_simplex_connectivity_core OK");
    end else begin
      $display("tb_structured_cell_to_simplex_connectivity_core NOT OK");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("tb_structured_cell_to_simplex_connectivity_core NOT OK");
    $finish;
  end

endmodule
